// ===== hdl/fh64_pkg.sv =====
// ----------------------------------------------------------------------------
// fh64_pkg
// Constants, shared types and small helper functions for the streaming
// 64-bit fast hash.
// ----------------------------------------------------------------------------
`default_nettype none

package fh64_pkg;

  localparam logic [63:0] MIX_MUL  = 64'h2127599bf4325c37;
  localparam logic [63:0] HASH_MUL = 64'h880355f21e6d1965;
  localparam int unsigned SHIFT_A  = 23;
  localparam int unsigned SHIFT_B  = 47;

  // Request from the sequencer to the shared multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // Result returned by the shared multiplier.
  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] xs_a(input logic [63:0] v);
    return v ^ (v >> SHIFT_A);
  endfunction

  function automatic logic [63:0] xs_b(input logic [63:0] v);
    return v ^ (v >> SHIFT_B);
  endfunction

  // Keeps the low tail bytes of a word; a tail of zero keeps the whole word.
  function automatic logic [63:0] tail_mask(input logic [2:0] tail);
    logic [2:0] drop;
    drop = 3'(~tail + 3'd1);
    return {64{1'b1}} >> {drop, 3'b000};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fast_hash_64_stream.sv =====
// ----------------------------------------------------------------------------
// fast_hash_64_stream
// Streaming 64-bit fast hash of a key delivered as little-endian words.
// ----------------------------------------------------------------------------
// Usage: key words enter on in_valid/in_stall, one request per 64-bit word,
// with first_word and last_word marking the key's bounds; key_length is read
// on the first word. A word marked last produces one request on
// out_valid/out_stall carrying hash_value. Other words produce nothing.
// Timing: every 64-bit multiply runs on one shared 32x32 multiplier and ends
// with a hand-off through its done flag. A middle word needs two multiplies,
// a first word adds one multiply for the length, and a last word adds one
// more for the final mix plus the ST_FSTART state to start it. The input is
// stalled whenever a word is in progress.
// Reset: rst clears the running hash, tail count and empty-key flag, and
// drops any pending result.
// Output stall: a result waits in the output register. The next word is still
// accepted and absorbed, but its final mix starts only once the output
// register has been emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_hash_64_stream (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [63:0] key_word,
  input  wire logic [31:0] key_length,
  input  wire logic        first_word,
  input  wire logic        last_word,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] hash_value
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LEN    = 6'b000010,
    ST_MIX    = 6'b000100,
    ST_HASH   = 6'b001000,
    ST_FSTART = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [63:0]        running_hash;
  logic [2:0]         tail_bytes;
  logic               empty_key;
  logic [63:0]        word_r;
  logic               last_r;
  logic               accept;
  logic               eff_empty;
  logic [2:0]         eff_tail;
  logic [63:0]        word_in;
  fh64_pkg::mul_req_t mreq;
  fh64_pkg::mul_rsp_t mrsp;

  fh64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // A first word sets the tail and empty flag that apply to itself.
  assign eff_empty = first_word ? (key_length == 32'd0) : empty_key;
  assign eff_tail  = first_word ? key_length[2:0] : tail_bytes;
  assign word_in   = last_word ? (key_word & fh64_pkg::tail_mask(eff_tail)) : key_word;

  always_comb begin
    state_next = state;
    mreq.start = 1'b0;
    mreq.a     = fh64_pkg::xs_a(word_r);
    mreq.b     = fh64_pkg::MIX_MUL;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (first_word) begin
            mreq.start = 1'b1;
            mreq.a     = {32'd0, key_length};
            mreq.b     = fh64_pkg::HASH_MUL;
            state_next = ST_LEN;
          end else if (!eff_empty) begin
            mreq.start = 1'b1;
            mreq.a     = fh64_pkg::xs_a(word_in);
            state_next = ST_MIX;
          end else if (last_word) begin
            state_next = ST_FSTART;
          end
        end
      end
      ST_LEN: begin
        if (mrsp.done) begin
          if (!empty_key) begin
            mreq.start = 1'b1;
            state_next = ST_MIX;
          end else if (last_r) begin
            state_next = ST_FSTART;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MIX: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = running_hash ^ fh64_pkg::xs_b(mrsp.product);
          mreq.b     = fh64_pkg::HASH_MUL;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mrsp.done) state_next = last_r ? ST_FSTART : ST_IDLE;
      end
      ST_FSTART: begin
        if (!out_valid) begin
          mreq.start = 1'b1;
          mreq.a     = fh64_pkg::xs_a(running_hash);
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (mrsp.done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_hash <= 64'd0;
      tail_bytes   <= 3'd0;
      empty_key    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && first_word) begin
        tail_bytes <= key_length[2:0];
        empty_key  <= (key_length == 32'd0);
      end
      if (mrsp.done && (state == ST_LEN || state == ST_HASH)) begin
        running_hash <= mrsp.product;
      end
      if (state == ST_FIN && mrsp.done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= word_in;
      last_r <= last_word;
    end
    if (state == ST_FIN && mrsp.done) begin
      hash_value <= fh64_pkg::xs_b(mrsp.product);
    end
  end

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (state == ST_LEN || state == ST_MIX || state == ST_HASH || state == ST_FIN))
    else $error("multiplier finished with no multiply outstanding");

  a_fin_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> !out_valid)
    else $error("final mix running while a result is still pending");

  a_first_len: assert property (@(posedge clk) disable iff (rst)
    (accept && first_word) |=> (state == ST_LEN))
    else $error("first word did not start the length multiply");

  a_empty_skip: assert property (@(posedge clk) disable iff (rst)
    (accept && !first_word && empty_key && !last_word) |=> (state == ST_IDLE))
    else $error("word of an empty key was not ignored");

  a_out_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && mrsp.done) |=> out_valid)
    else $error("final hash not presented");
`endif

endmodule

`default_nettype wire

// ===== hdl/fh64_mul.sv =====
// ----------------------------------------------------------------------------
// fh64_mul
// Shared 64x64 multiplier giving the low 64 product bits in the steps MS_LL,
// MS_LH and MS_HL with a single 32x32 multiplier and an accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fh64_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fh64_pkg::mul_req_t req,
  output      fh64_pkg::mul_rsp_t rsp
);

  typedef enum logic [3:0] {
    MS_IDLE = 4'b0001,
    MS_LL   = 4'b0010,
    MS_LH   = 4'b0100,
    MS_HL   = 4'b1000
  } mul_state_t;

  mul_state_t  state;
  mul_state_t  state_next;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc;
  logic        done;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;

  // The cross terms only reach the upper half of the low product.
  always_comb begin
    op_x = a_r[31:0];
    op_y = b_r[31:0];
    state_next = state;
    unique case (state)
      MS_IDLE: begin
        if (req.start) state_next = MS_LL;
      end
      MS_LL: begin
        state_next = MS_LH;
      end
      MS_LH: begin
        op_y = b_r[63:32];
        state_next = MS_HL;
      end
      MS_HL: begin
        op_x = a_r[63:32];
        state_next = MS_IDLE;
      end
      default: state_next = MS_IDLE;
    endcase
  end

  assign prod = op_x * op_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MS_HL);
    end
  end

  always_ff @(posedge clk) begin
    if (state == MS_IDLE && req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    unique case (state)
      MS_IDLE: ;
      MS_LL:   acc <= prod;
      MS_LH:   acc[63:32] <= acc[63:32] + prod[31:0];
      MS_HL:   acc[63:32] <= acc[63:32] + prod[31:0];
      default: ;
    endcase
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

`default_nettype wire
